[sv/x86d_pkg.sv]
// Package for the 8086 instruction byte decoder.
// Holds the decode phase, form and operation codes, the record type and the opcode helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package x86d_pkg;

  // Width of the running byte offset into the code stream (16 to 32).
  localparam int unsigned OFFSET_WIDTH = 16;

  // Phase of the byte-level decode machine.
  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_MODRM   = 3'd1,
    PH_DISP_LO = 3'd2,
    PH_DISP_HI = 3'd3,
    PH_IMM_LO  = 3'd4,
    PH_IMM_HI  = 3'd5,
    PH_JUMP    = 3'd6
  } phase_e;

  // Instruction form; FORM_NONE marks an opcode outside the subset.
  typedef enum logic [2:0] {
    FORM_REGMEM  = 3'd0,
    FORM_IMM_REG = 3'd1,
    FORM_IMM_ACC = 3'd2,
    FORM_IMM_RM  = 3'd3,
    FORM_JUMP    = 3'd4,
    FORM_NONE    = 3'd7
  } form_e;

  typedef enum logic [2:0] {
    OPER_MOV  = 3'd0,
    OPER_ADD  = 3'd1,
    OPER_SUB  = 3'd2,
    OPER_CMP  = 3'd3,
    OPER_JUMP = 3'd4
  } oper_e;

  // Immediate-group extensions that are supported.
  localparam logic [2:0] EXT_ADD = 3'd0;
  localparam logic [2:0] EXT_SUB = 3'd5;
  localparam logic [2:0] EXT_CMP = 3'd7;

  // ModRM mod values and the direct-address rm pattern.
  localparam logic [1:0] MOD_MEM    = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP16 = 2'd2;
  localparam logic [2:0] RM_DIRECT  = 3'd6;

  // Jump kinds for the loop family start after the sixteen conditions.
  localparam logic [4:0] JUMP_KIND_LOOP_BASE = 5'd16;

  // One decoded-instruction item.
  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  jump_kind;
    logic [2:0]  form;
    logic        to_register;
    logic        wide;
    logic [1:0]  mod_field;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [15:0] jump_target;
    logic        error_code;
  } rec_t;

  // Form of an opcode, checked in priority order.
  function automatic form_e op_form(input logic [7:0] op);
    form_e f;
    f = FORM_NONE;
    if (op[7:2] == 6'h22)                          f = FORM_REGMEM;
    else if (op[7:4] == 4'hB)                      f = FORM_IMM_REG;
    else if (op[7:2] == 6'h00)                     f = FORM_REGMEM;
    else if (op[7:2] == 6'h0E)                     f = FORM_REGMEM;
    else if (op[7:1] == 7'h02)                     f = FORM_IMM_ACC;
    else if (op[7:1] == 7'h16)                     f = FORM_IMM_ACC;
    else if (op[7:1] == 7'h1E)                     f = FORM_IMM_ACC;
    else if (op[7:2] == 6'h0A)                     f = FORM_REGMEM;
    else if (op[7:2] == 6'h20)                     f = FORM_IMM_RM;
    else if (op[7:4] == 4'h7 || op[7:2] == 6'h38)  f = FORM_JUMP;
    return f;
  endfunction

  // Operation of an opcode; the immediate group is resolved by its extension.
  function automatic oper_e op_oper(input logic [7:0] op, input logic [2:0] ext);
    oper_e o;
    o = OPER_MOV;
    if (op[7:2] == 6'h22 || op[7:4] == 4'hB)                        o = OPER_MOV;
    else if (op[7:2] == 6'h00 || op[7:1] == 7'h02)                  o = OPER_ADD;
    else if (op[7:2] == 6'h0E || op[7:1] == 7'h1E)                  o = OPER_CMP;
    else if (op[7:1] == 7'h16 || op[7:2] == 6'h0A)                  o = OPER_SUB;
    else if (op[7:2] == 6'h20) begin
      if (ext == EXT_SUB)      o = OPER_SUB;
      else if (ext == EXT_CMP) o = OPER_CMP;
      else                     o = OPER_ADD;
    end else if (op[7:4] == 4'h7 || op[7:2] == 6'h38)               o = OPER_JUMP;
    return o;
  endfunction

  // True when the immediate of this opcode takes two bytes.
  function automatic logic imm_is_word(input logic [7:0] op);
    logic w;
    unique case (op_form(op))
      FORM_IMM_REG: w = op[3];
      FORM_IMM_ACC: w = op[0];
      default:      w = (op[1:0] == 2'b01);
    endcase
    return w;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

  // Record for an unknown or unsupported instruction.
  function automatic rec_t error_rec();
    rec_t r;
    r = '0;
    r.error_code = 1'b1;
    return r;
  endfunction

  // Record for a completed instruction, from its latched and current fields.
  function automatic rec_t build_rec(input logic [7:0] op, input logic [7:0] modrm,
                                     input logic [15:0] disp, input logic [15:0] imm,
                                     input logic [15:0] target);
    rec_t  r;
    form_e f;
    f = op_form(op);
    r = '0;
    r.operation = op_oper(op, modrm[5:3]);
    r.form      = f;
    unique case (f)
      FORM_REGMEM: begin
        r.mod_field    = modrm[7:6];
        r.reg_field    = modrm[5:3];
        r.rm_field     = modrm[2:0];
        r.displacement = disp;
        r.wide         = op[0];
        r.to_register  = op[1];
      end
      FORM_IMM_RM: begin
        r.mod_field    = modrm[7:6];
        r.reg_field    = modrm[5:3];
        r.rm_field     = modrm[2:0];
        r.displacement = disp;
        r.wide         = op[0];
        r.immediate    = imm;
      end
      FORM_IMM_REG: begin
        r.to_register = 1'b1;
        r.wide        = op[3];
        r.reg_field   = op[2:0];
        r.immediate   = imm;
      end
      FORM_IMM_ACC: begin
        r.to_register = 1'b1;
        r.wide        = op[0];
        r.immediate   = imm;
      end
      FORM_JUMP: begin
        r.jump_kind   = (op[7:4] == 4'h7) ? {1'b0, op[3:0]}
                                          : JUMP_KIND_LOOP_BASE + {3'b000, op[1:0]};
        r.jump_target = target;
      end
      default: r = error_rec();
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/x86d_decode_core.sv]
// Byte-level decode machine for the 8086 instruction byte decoder.
// Holds the phase, the opcode, ModRM, displacement and immediate latches and the stream offset.
// Depends on x86d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86d_decode_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire logic [7:0]    code_byte_i,
  output logic               emit_o,
  output x86d_pkg::rec_t     rec_o
);
  import x86d_pkg::*;

  phase_e                    phase_q, phase_d;
  logic [7:0]                opcode_q, opcode_d;
  logic [7:0]                modrm_q, modrm_d;
  logic [15:0]               disp_q, disp_d;
  logic [15:0]               imm_q, imm_d;
  logic [OFFSET_WIDTH-1:0]   offset_q, offset_d;

  form_e                     lead_form;
  form_e                     cur_form;
  logic                      needs_disp;
  logic                      bad_ext;
  logic [15:0]               target;

  // Every accepted byte advances the stream offset.
  assign offset_d = offset_q + OFFSET_WIDTH'(1);

  assign lead_form  = op_form(code_byte_i);
  assign cur_form   = op_form(opcode_q);
  assign needs_disp = (code_byte_i[7:6] == MOD_DISP8) || (code_byte_i[7:6] == MOD_DISP16) ||
                      (code_byte_i[7:6] == MOD_MEM && code_byte_i[2:0] == RM_DIRECT);
  assign bad_ext    = (cur_form == FORM_IMM_RM) && (code_byte_i[5:3] != EXT_ADD) &&
                      (code_byte_i[5:3] != EXT_SUB) && (code_byte_i[5:3] != EXT_CMP);
  assign target     = offset_d[15:0] + sext8(code_byte_i);

  // Next phase, latch updates and the record for a completing instruction.
  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    modrm_d  = modrm_q;
    disp_d   = disp_q;
    imm_d    = imm_q;
    emit_o   = 1'b0;
    rec_o    = '0;
    unique case (phase_q)
      PH_OPCODE: begin
        opcode_d = code_byte_i;
        modrm_d  = '0;
        disp_d   = '0;
        imm_d    = '0;
        unique case (lead_form)
          FORM_REGMEM, FORM_IMM_RM:   phase_d = PH_MODRM;
          FORM_IMM_REG, FORM_IMM_ACC: phase_d = PH_IMM_LO;
          FORM_JUMP:                  phase_d = PH_JUMP;
          default: begin
            emit_o = 1'b1;
            rec_o  = error_rec();
          end
        endcase
      end
      PH_MODRM: begin
        modrm_d = code_byte_i;
        if (bad_ext) begin
          emit_o  = 1'b1;
          rec_o   = error_rec();
          phase_d = PH_OPCODE;
        end else if (needs_disp) begin
          phase_d = PH_DISP_LO;
        end else if (cur_form == FORM_REGMEM) begin
          emit_o  = 1'b1;
          rec_o   = build_rec(opcode_q, code_byte_i, disp_q, imm_q, 16'h0000);
          phase_d = PH_OPCODE;
        end else begin
          phase_d = PH_IMM_LO;
        end
      end
      PH_DISP_LO: begin
        if (modrm_q[7:6] == MOD_DISP8) begin
          disp_d = sext8(code_byte_i);
          if (cur_form == FORM_REGMEM) begin
            emit_o  = 1'b1;
            rec_o   = build_rec(opcode_q, modrm_q, sext8(code_byte_i), imm_q, 16'h0000);
            phase_d = PH_OPCODE;
          end else begin
            phase_d = PH_IMM_LO;
          end
        end else begin
          disp_d  = {8'h00, code_byte_i};
          phase_d = PH_DISP_HI;
        end
      end
      PH_DISP_HI: begin
        disp_d = {code_byte_i, disp_q[7:0]};
        if (cur_form == FORM_REGMEM) begin
          emit_o  = 1'b1;
          rec_o   = build_rec(opcode_q, modrm_q, {code_byte_i, disp_q[7:0]}, imm_q, 16'h0000);
          phase_d = PH_OPCODE;
        end else begin
          phase_d = PH_IMM_LO;
        end
      end
      PH_IMM_LO: begin
        if (imm_is_word(opcode_q)) begin
          imm_d   = {8'h00, code_byte_i};
          phase_d = PH_IMM_HI;
        end else begin
          imm_d   = sext8(code_byte_i);
          emit_o  = 1'b1;
          rec_o   = build_rec(opcode_q, modrm_q, disp_q, sext8(code_byte_i), 16'h0000);
          phase_d = PH_OPCODE;
        end
      end
      PH_IMM_HI: begin
        imm_d   = {code_byte_i, imm_q[7:0]};
        emit_o  = 1'b1;
        rec_o   = build_rec(opcode_q, modrm_q, disp_q, {code_byte_i, imm_q[7:0]}, 16'h0000);
        phase_d = PH_OPCODE;
      end
      PH_JUMP: begin
        emit_o  = 1'b1;
        rec_o   = build_rec(opcode_q, modrm_q, disp_q, imm_q, target);
        phase_d = PH_OPCODE;
      end
      default: begin
        phase_d = PH_OPCODE;
      end
    endcase
  end

  // State advances only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_OPCODE;
      opcode_q <= '0;
      modrm_q  <= '0;
      disp_q   <= '0;
      imm_q    <= '0;
      offset_q <= '0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      modrm_q  <= modrm_d;
      disp_q   <= disp_d;
      imm_q    <= imm_d;
      offset_q <= offset_d;
    end
  end

endmodule

`default_nettype wire

[sv/x86_16_instruction_byte_decoder.sv]
// Output: a completing byte's record is registered and shows in the cycle after acceptance.
// Throughput: one code byte per cycle unless the output stalls; the single output register
// takes a new record in the same cycle that the previous one is taken downstream.
// Reset: asynchronous, active low; the decoder then expects an opcode byte at offset zero.
// Depends on x86d_pkg and x86d_decode_core.
`timescale 1ns / 1ps
`default_nettype none

module x86_16_instruction_byte_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  code_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       operation_o,
  output logic [4:0]       jump_kind_o,
  output logic [2:0]       form_o,
  output logic             to_register_o,
  output logic             wide_o,
  output logic [1:0]       mod_field_o,
  output logic [2:0]       reg_field_o,
  output logic [2:0]       rm_field_o,
  output logic [15:0]      displacement_o,
  output logic [15:0]      immediate_o,
  output logic [15:0]      jump_target_o,
  output logic             error_code_o
);
  import x86d_pkg::*;

  logic  take;
  logic  emit;
  rec_t  rec;
  rec_t  rec_q;
  logic  out_valid_q;

  // A byte is taken whenever the output register is free or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  x86d_decode_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .code_byte_i (code_byte_i),
    .emit_o      (emit),
    .rec_o       (rec)
  );

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output record register.
  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      rec_q <= rec;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign operation_o    = rec_q.operation;
  assign jump_kind_o    = rec_q.jump_kind;
  assign form_o         = rec_q.form;
  assign to_register_o  = rec_q.to_register;
  assign wide_o         = rec_q.wide;
  assign mod_field_o    = rec_q.mod_field;
  assign reg_field_o    = rec_q.reg_field;
  assign rm_field_o     = rec_q.rm_field;
  assign displacement_o = rec_q.displacement;
  assign immediate_o    = rec_q.immediate;
  assign jump_target_o  = rec_q.jump_target;
  assign error_code_o   = rec_q.error_code;

endmodule

`default_nettype wire
